FILE: sv/banked_memory_mapper_unit_macros.svh
// Assertion macros for the mapper RTL.
`ifndef BANKED_MEMORY_MAPPER_UNIT_MACROS_SVH
`define BANKED_MEMORY_MAPPER_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BMM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion, checked during reset too.
`define BMM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/bmm_pkg.sv
// Types, codes and constants for the banked memory mapper.
`timescale 1ns / 1ps

package bmm_pkg;

	localparam int MAIN_RAM_PAGES = 32;
	localparam int FLASH_PAGES    = 16;

	localparam int FUNC_W   = 3;
	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int TGT_W    = 3;
	localparam int OFFSET_W = 19;
	localparam int PAGE_W   = 6;
	localparam int SLOT_OFF_W = 14;
	localparam int NUM_SLOTS  = 4;
	localparam int SLOT_W     = 2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CART_PRESENT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXT_DISABLE  = 1'd1;

	localparam logic [FUNC_W-1:0] FUNC_MEM_RD   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_MEM_WR   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_BANK_WR  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REMAP_WR = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_BANK_RD  = 3'd4;

	localparam logic [TGT_W-1:0] TGT_NONE   = 3'd0;
	localparam logic [TGT_W-1:0] TGT_FLASH  = 3'd1;
	localparam logic [TGT_W-1:0] TGT_CART   = 3'd2;
	localparam logic [TGT_W-1:0] TGT_VIDEO  = 3'd3;
	localparam logic [TGT_W-1:0] TGT_CHAR   = 3'd4;
	localparam logic [TGT_W-1:0] TGT_MAIN   = 3'd5;
	localparam logic [TGT_W-1:0] TGT_SCREEN = 3'd6;
	localparam logic [TGT_W-1:0] TGT_COLOR  = 3'd7;

	localparam logic [PAGE_W-1:0] PAGE_CART  = 6'd19;
	localparam logic [PAGE_W-1:0] PAGE_VIDEO = 6'd20;
	localparam logic [PAGE_W-1:0] PAGE_CHAR  = 6'd21;

	localparam logic [SLOT_OFF_W-1:0] CHAR_RAM_SIZE = 14'h0800;
	localparam logic [DATA_W-1:0]     FLOAT_BYTE    = 8'hFF;

	localparam int BIT_OVERLAY   = 6;
	localparam int BIT_READ_ONLY = 7;

	typedef struct packed {
		logic [NUM_SLOTS-1:0][DATA_W-1:0] slot_regs;
		logic                             remap;
		logic                             cart_present;
		logic                             ext_disable;
	} bank_state_t;

	typedef struct packed {
		logic [TGT_W-1:0]    target_memory;
		logic [OFFSET_W-1:0] memory_offset;
		logic                write_strobe;
		logic [DATA_W-1:0]   reg_read_data;
	} result_t;

endpackage

FILE: sv/bmm_ifs.sv
// Request and response channel interfaces of the mapper.
`timescale 1ns / 1ps

interface bmm_req_if import bmm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] cpu_address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, func, cpu_address, write_data, input ready);
	modport sink (input valid, func, cpu_address, write_data, output ready);
endinterface

interface bmm_rsp_if import bmm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TGT_W-1:0]    target_memory;
	logic [OFFSET_W-1:0] memory_offset;
	logic                write_strobe;
	logic [DATA_W-1:0]   reg_read_data;

	modport source (output valid, target_memory, memory_offset, write_strobe, reg_read_data,
		input ready);
	modport sink (input valid, target_memory, memory_offset, write_strobe, reg_read_data,
		output ready);
endinterface

FILE: sv/banked_memory_mapper_unit.sv
// Banked memory mapper: top level with request handshake and result register.
//
// Usage:
//   req carries one CPU operation per transfer (func, cpu_address, write_data):
//   memory read, memory write, bank register write, remap write or bank
//   register read. rsp returns exactly one result per request: target memory,
//   byte offset inside it, write strobe and bank register read data.
//   A request taken at a clock edge shows its result on rsp from the next
//   cycle on. Throughput is one request per cycle while rsp is not stalled,
//   set by the single translation stage in front of the result register.
//   Bank register and remap updates take effect for the next request.
//   cfg_we/cfg_index/cfg_wdata write cartridge_present (index 0) and
//   ext_disable (index 1); write them only while no result is pending.
//   Reset clears the bank registers, remap flag, configuration and the result
//   valid flag. When the receiver stalls, the result holds and req.ready
//   drops until the result is taken; a new request is accepted in the same
//   cycle that the waiting result is taken.
`timescale 1ns / 1ps

`include "banked_memory_mapper_unit_macros.svh"

module banked_memory_mapper_unit import bmm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	bmm_req_if.sink                req,
	bmm_rsp_if.source              rsp
);

	bank_state_t state;
	result_t     result;
	result_t     result_q;
	logic        valid_q;
	logic        accept;

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	bmm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.upd_en     (accept),
		.func       (req.func),
		.slot_sel   (req.cpu_address[SLOT_W-1:0]),
		.write_data (req.write_data),
		.state      (state)
	);

	bmm_decode u_decode (
		.func        (req.func),
		.cpu_address (req.cpu_address),
		.state       (state),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.ready) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			result_q <= result;
	end

	assign rsp.valid         = valid_q;
	assign rsp.target_memory = result_q.target_memory;
	assign rsp.memory_offset = result_q.memory_offset;
	assign rsp.write_strobe  = result_q.write_strobe;
	assign rsp.reg_read_data = result_q.reg_read_data;

	`BMM_ASSERT(a_ready_rule, clk, arst_n, req.ready == (!valid_q || rsp.ready), "ready does not follow result register state")
	`BMM_ASSERT(a_nonmem_none, clk, arst_n, accept && req.func != FUNC_MEM_RD && req.func != FUNC_MEM_WR |=> rsp.target_memory == TGT_NONE && !rsp.write_strobe, "non-memory op produced a memory access")
	`BMM_ASSERT(a_strobe_target, clk, arst_n, rsp.valid && rsp.write_strobe |-> rsp.target_memory != TGT_NONE && rsp.target_memory != TGT_FLASH && rsp.target_memory != TGT_CART, "write strobe to a non-writable target")
	`BMM_ASSERT(a_none_offset, clk, arst_n, rsp.valid && rsp.target_memory == TGT_NONE |-> rsp.memory_offset == '0, "floating target with nonzero offset")
	`BMM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !valid_q, "result valid during reset")

endmodule

FILE: sv/bmm_regs.sv
// Bank registers, remap flag and configuration registers.
`timescale 1ns / 1ps

module bmm_regs import bmm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   upd_en,
	input  logic [FUNC_W-1:0]      func,
	input  logic [SLOT_W-1:0]      slot_sel,
	input  logic [DATA_W-1:0]      write_data,
	output bank_state_t            state
);

	bank_state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CART_PRESENT: state_q.cart_present <= cfg_wdata[0];
					CFG_EXT_DISABLE:  state_q.ext_disable  <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (upd_en) begin
				case (func)
					FUNC_BANK_WR: begin
						if (!state_q.ext_disable)
							state_q.slot_regs[slot_sel] <= write_data;
					end
					FUNC_REMAP_WR: state_q.remap <= write_data[0];
					default: ;
				endcase
			end
		end
	end

	assign state = state_q;

endmodule

FILE: sv/bmm_decode.sv
// Address translation and bank register read for one request.
`timescale 1ns / 1ps

module bmm_decode import bmm_pkg::*; (
	input  logic [FUNC_W-1:0] func,
	input  logic [ADDR_W-1:0] cpu_address,
	input  bank_state_t       state,
	output result_t           result
);

	logic [SLOT_W-1:0]     cpu_slot;
	logic [SLOT_W-1:0]     rd_slot;
	logic [SLOT_OFF_W-1:0] off;
	logic [DATA_W-1:0]     bank_reg;
	logic [PAGE_W-1:0]     page;
	logic [TGT_W-1:0]      tgt;
	logic [OFFSET_W-1:0]   moff;
	logic                  writable;
	logic                  is_mem;

	assign cpu_slot = cpu_address[ADDR_W-1 -: SLOT_W];
	assign off      = cpu_address[SLOT_OFF_W-1:0];

	// Single read port on the bank registers; remap exchanges slots 0 and 3.
	always_comb begin
		if (func == FUNC_BANK_RD)
			rd_slot = cpu_address[SLOT_W-1:0];
		else if (state.remap && (cpu_slot == 2'd0 || cpu_slot == 2'd3))
			rd_slot = ~cpu_slot;
		else
			rd_slot = cpu_slot;
	end

	assign bank_reg = state.slot_regs[rd_slot];
	assign page     = bank_reg[PAGE_W-1:0];

	always_comb begin
		tgt      = TGT_NONE;
		moff     = '0;
		writable = 1'b0;
		if (bank_reg[BIT_OVERLAY] && off[13:12] == 2'b11) begin
			writable = 1'b1;
			case (off[11:10])
				2'b00: begin
					tgt  = TGT_SCREEN;
					moff = OFFSET_W'(off[9:0]);
				end
				2'b01: begin
					tgt  = TGT_COLOR;
					moff = OFFSET_W'(off[9:0]);
				end
				default: begin
					tgt  = TGT_MAIN;
					moff = OFFSET_W'(off);
				end
			endcase
		end else if (page < PAGE_W'(FLASH_PAGES)) begin
			tgt  = TGT_FLASH;
			moff = {page[4:0], off};
		end else if (page == PAGE_CART) begin
			if (state.cart_present) begin
				tgt  = TGT_CART;
				moff = OFFSET_W'(off);
			end
		end else if (page == PAGE_VIDEO) begin
			tgt      = TGT_VIDEO;
			moff     = OFFSET_W'(off);
			writable = !bank_reg[BIT_READ_ONLY];
		end else if (page == PAGE_CHAR && off < CHAR_RAM_SIZE) begin
			tgt      = TGT_CHAR;
			moff     = OFFSET_W'(off);
			writable = !bank_reg[BIT_READ_ONLY];
		end else if (page[5] && {1'b0, page[4:0]} < PAGE_W'(MAIN_RAM_PAGES)) begin
			// main RAM pages start at 32, so the low five bits are the RAM page
			tgt      = TGT_MAIN;
			moff     = {page[4:0], off};
			writable = !bank_reg[BIT_READ_ONLY];
		end
	end

	assign is_mem = (func == FUNC_MEM_RD) || (func == FUNC_MEM_WR);

	always_comb begin
		result.target_memory = is_mem ? tgt : TGT_NONE;
		result.memory_offset = is_mem ? moff : '0;
		result.write_strobe  = (func == FUNC_MEM_WR) && writable;
		result.reg_read_data = (func == FUNC_BANK_RD && !state.ext_disable) ? bank_reg
			: FLOAT_BYTE;
	end

endmodule
